@@ rtl/sorted_deadline_timer_queue_unit_macros.svh @@
// Assertion macros used by the checker of the sorted deadline timer queue.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_UNIT_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SDTQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sdtq assertion failed");

// Next-cycle implication, disabled during reset.
`define SDTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sdtq assertion failed");

`endif

@@ rtl/sdtq_pkg.sv @@
// Types, codes and helpers shared by the timer queue modules.
`timescale 1ns / 1ps
`default_nettype none
package sdtq_pkg;
    localparam int FUNC_W  = 3;
    localparam int ID_W    = 4;
    localparam int TIME_W  = 48;
    localparam int DELAY_W = 24;
    localparam int PROD_W  = 34;
    localparam logic [9:0] US_PER_MS = 10'd1000;

    localparam logic [FUNC_W-1:0] FUNC_ARM    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DISARM = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIRE   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_AGE    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd4;

    localparam logic [2:0] EM_STATUS = 3'd0;
    localparam logic [2:0] EM_OK     = 3'd1;
    localparam logic [2:0] EM_FIRE   = 3'd2;
    localparam logic [2:0] EM_QUERY  = 3'd3;
    localparam logic [2:0] EM_AGE    = 3'd4;

    typedef struct packed {
        logic       load;
        logic       find;
        logic       remove;
        logic       pop;
        logic       add_dl;
        logic       cmp_le;
        logic       insert;
        logic       emit;
        logic [2:0] emit_sel;
    } sdtq_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              id_ok;
        logic              found;
        logic              age_pop;
        logic              age_last;
        logic              out_free;
    } sdtq_status_t;

    // a - b as a signed 48-bit value, saturated at both bounds.
    function automatic logic [TIME_W-1:0] diff_sat(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [TIME_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[TIME_W] != d[TIME_W-1])
            return d[TIME_W] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}};
        return d[TIME_W-1:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/sorted_deadline_timer_queue_unit.sv @@
// Sorted deadline timer queue: top level joining controller and datapath.
//
// Input channel: in_valid / in_stall carry one command (func, timer_id, time_us,
// delay_ms); a transfer takes place when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall carry result items; each command gives
// one result, except age, which gives one result per expired timer (a single
// one when none has expired), earliest first, with last set on the final one.
// Sequence: a command is taken into the input registers and its compare
// vectors are registered in the find state; disarm, fire now, query and
// unknown codes register their result in the do state, arm steps through
// removal of an earlier entry, saturating add of the delay product, insert
// compare and ordered insert, and age gives its results one by one from the
// age state. The list is shifted in place, one shift per removed or inserted
// entry. Only one command is worked on at a time; in_stall is low whenever
// the controller is idle, even while the last result still waits in the
// output register.
// While out_stall is high the output register holds its result, and the
// controller waits before loading any further result.
// Reset empties the queue, clears out_valid and idles the controller; list
// contents need no clearing as only entries below the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module sorted_deadline_timer_queue_unit
    import sdtq_pkg::*;
#(
    parameter int TIMERS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [FUNC_W-1:0]   func,
    input  wire logic [ID_W-1:0]     timer_id,
    input  wire logic [TIME_W-1:0]   time_us,
    input  wire logic [DELAY_W-1:0]  delay_ms,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [ID_W-1:0]          fired_id,
    output logic                     fired,
    output logic                     status,
    output logic                     queue_empty,
    output logic signed [TIME_W-1:0] remaining_us,
    output logic                     last
);
    sdtq_cmd_t    cmd;
    sdtq_status_t st;

    // The controller steps through each operation and issues commands.
    sdtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the ordered list and the output register.
    sdtq_dp #(
        .TIMERS (TIMERS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .func         (func),
        .timer_id     (timer_id),
        .time_us      (time_us),
        .delay_ms     (delay_ms),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .fired_id     (fired_id),
        .fired        (fired),
        .status       (status),
        .queue_empty  (queue_empty),
        .remaining_us (remaining_us),
        .last         (last)
    );
endmodule
`default_nettype wire

@@ rtl/sdtq_ctrl.sv @@
// Controller state machine that sequences each timer queue operation.
`timescale 1ns / 1ps
`default_nettype none
module sdtq_ctrl
    import sdtq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire sdtq_status_t st,
    output sdtq_cmd_t         cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_DO   = 3'd2;
    localparam logic [2:0] S_DL   = 3'd3;
    localparam logic [2:0] S_LE   = 3'd4;
    localparam logic [2:0] S_INS  = 3'd5;
    localparam logic [2:0] S_AGE  = 3'd6;

    logic [2:0] state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = S_FIND;
            end
            S_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = S_DO;
            end
            S_DO:
            begin
                case (st.func)
                    FUNC_ARM:
                    begin
                        if (!st.id_ok)
                        begin
                            if (st.out_free)
                            begin
                                cmd.emit     = 1'b1;
                                cmd.emit_sel = EM_STATUS;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.remove = st.found;
                            state_next = S_DL;
                        end
                    end
                    FUNC_DISARM, FUNC_FIRE:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.remove = st.found;
                            if (!st.found)
                                cmd.emit_sel = EM_STATUS;
                            else if (st.func == FUNC_FIRE)
                                cmd.emit_sel = EM_FIRE;
                            else
                                cmd.emit_sel = EM_OK;
                            state_next = S_IDLE;
                        end
                    end
                    FUNC_AGE:
                        state_next = S_AGE;
                    FUNC_QUERY:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = st.found ? EM_QUERY : EM_STATUS;
                            state_next   = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = EM_OK;
                            state_next   = S_IDLE;
                        end
                    end
                endcase
            end
            S_DL:
            begin
                cmd.add_dl = 1'b1;
                state_next = S_LE;
            end
            S_LE:
            begin
                cmd.cmp_le = 1'b1;
                state_next = S_INS;
            end
            S_INS:
            begin
                if (st.out_free)
                begin
                    cmd.insert   = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EM_OK;
                    state_next   = S_IDLE;
                end
            end
            S_AGE:
            begin
                if (st.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EM_AGE;
                    cmd.pop      = st.age_pop;
                    if (st.age_last)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

@@ rtl/sdtq_dp.sv @@
// Datapath: the ordered timer list, its compare vectors and the result register.
`timescale 1ns / 1ps
`default_nettype none
module sdtq_dp
    import sdtq_pkg::*;
#(
    parameter int TIMERS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sdtq_cmd_t           cmd,
    output sdtq_status_t             st,
    input  wire logic [FUNC_W-1:0]   func,
    input  wire logic [ID_W-1:0]     timer_id,
    input  wire logic [TIME_W-1:0]   time_us,
    input  wire logic [DELAY_W-1:0]  delay_ms,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output logic [ID_W-1:0]          fired_id,
    output logic                     fired,
    output logic                     status,
    output logic                     queue_empty,
    output logic signed [TIME_W-1:0] remaining_us,
    output logic                     last
);
    localparam int CW = $clog2(TIMERS + 1);

    logic [ID_W-1:0]    ids_reg [TIMERS];
    logic [TIME_W-1:0]  dl_reg  [TIMERS];
    logic [CW-1:0]      count_reg, count_next;
    logic [FUNC_W-1:0]  func_reg;
    logic [ID_W-1:0]    id_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TIME_W-1:0]  newdl_reg;
    logic [TIMERS-1:0]  match_reg, rmmask_reg, expv_reg, le_reg;
    logic               age_empty_reg;
    logic               out_valid_reg;

    logic [TIMERS-1:0]  valid_c, match_c, rmmask_c, expv_c, le_c;
    logic [TIME_W-1:0]  qdl_c, diff_a_c, diff_c;
    logic [TIME_W:0]    sum_c;
    logic               out_free_c, empty_c;
    logic               exp0_c, age_last_c;

    always_comb
    begin
        logic acc;
        acc   = 1'b0;
        qdl_c = '0;
        for (int i = 0; i < TIMERS; i++)
        begin
            valid_c[i]  = (CW'(i) < count_reg);
            match_c[i]  = valid_c[i] && (ids_reg[i] == id_reg);
            acc         = acc | match_c[i];
            rmmask_c[i] = acc;
            expv_c[i]   = valid_c[i] && (dl_reg[i] <= now_reg);
            le_c[i]     = valid_c[i] && (dl_reg[i] <= newdl_reg);
            qdl_c       = qdl_c | (dl_reg[i] & {TIME_W{match_reg[i]}});
        end
    end

    assign sum_c      = {1'b0, now_reg} + (TIME_W + 1)'(prod_reg);
    assign exp0_c     = expv_reg[0];
    assign age_last_c = !expv_reg[0] || !expv_reg[1];
    assign diff_a_c   = (cmd.emit_sel == EM_QUERY) ? qdl_c : (exp0_c ? dl_reg[1] : dl_reg[0]);
    assign diff_c     = diff_sat(diff_a_c, now_reg);
    assign out_free_c = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (cmd.remove || cmd.pop)
            count_next = count_reg - CW'(1);
        else if (cmd.insert)
            count_next = count_reg + CW'(1);
        else
            count_next = count_reg;
    end

    assign empty_c = (cmd.emit_sel == EM_AGE) ? age_empty_reg : (count_next == '0);

    assign st.func     = func_reg;
    assign st.id_ok    = (32'(id_reg) < TIMERS);
    assign st.found    = |match_reg;
    assign st.age_pop  = exp0_c;
    assign st.age_last = age_last_c;
    assign st.out_free = out_free_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Shift the list down over the removed entry, or up to open a gap.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TIMERS; i++)
        begin
            int nx;
            int pv;
            nx = (i < TIMERS - 1) ? i + 1 : i;
            pv = (i > 0) ? i - 1 : 0;
            if ((cmd.remove && rmmask_reg[i]) || cmd.pop)
            begin
                ids_reg[i] <= ids_reg[nx];
                dl_reg[i]  <= dl_reg[nx];
            end
            else if (cmd.insert && !le_reg[i])
            begin
                if (i == 0 || le_reg[pv])
                begin
                    ids_reg[i] <= id_reg;
                    dl_reg[i]  <= newdl_reg;
                end
                else
                begin
                    ids_reg[i] <= ids_reg[pv];
                    dl_reg[i]  <= dl_reg[pv];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            id_reg    <= timer_id;
            now_reg   <= time_us;
            delay_reg <= delay_ms;
        end
        if (cmd.find)
        begin
            match_reg     <= match_c;
            rmmask_reg    <= rmmask_c;
            expv_reg      <= expv_c;
            age_empty_reg <= (expv_c == valid_c);
            prod_reg      <= PROD_W'(delay_reg) * PROD_W'(US_PER_MS);
        end
        else if (cmd.pop)
            expv_reg <= expv_reg >> 1;
        if (cmd.add_dl)
            newdl_reg <= sum_c[TIME_W] ? {TIME_W{1'b1}} : sum_c[TIME_W-1:0];
        if (cmd.cmp_le)
            le_reg <= le_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            fired_id     <= '0;
            fired        <= 1'b0;
            status       <= 1'b0;
            queue_empty  <= empty_c;
            remaining_us <= '0;
            last         <= 1'b1;
            case (cmd.emit_sel)
                EM_STATUS: status <= 1'b1;
                EM_OK:     status <= 1'b0;
                EM_FIRE:
                begin
                    fired_id <= id_reg;
                    fired    <= 1'b1;
                end
                EM_QUERY:  remaining_us <= diff_c;
                EM_AGE:
                begin
                    last <= age_last_c;
                    if (exp0_c)
                    begin
                        fired_id <= ids_reg[0];
                        fired    <= 1'b1;
                        if (age_last_c && valid_c[1])
                            remaining_us <= diff_c;
                    end
                    else if (valid_c[0])
                        remaining_us <= diff_c;
                end
                default:   status <= 1'b0;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

@@ rtl/sdtq_checker.sv @@
// Port-level checker for the timer queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_deadline_timer_queue_unit_macros.svh"
module sdtq_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [3:0] fired_id,
    input wire logic       fired,
    input wire logic       status,
    input wire logic       last
);
    `SDTQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `SDTQ_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
    `SDTQ_ASSERT_NOW(a_fire_ok, clk, rst_n, out_valid && fired, !status)
    `SDTQ_ASSERT_NOW(a_mid_is_fire, clk, rst_n, out_valid && !last, fired && !status)
    `SDTQ_ASSERT_NOW(a_idle_id, clk, rst_n, out_valid && !fired, fired_id == 4'd0)
endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker u_sdtq_checker (.*);
`default_nettype wire

@@ tb/sv/sorted_deadline_timer_queue_unit_checker.sv @@
// Checker that predicts and compares the results of the sorted deadline timer queue.
`timescale 1ns / 1ps
module sorted_deadline_timer_queue_unit_checker
    import sdtq_pkg::*;
#(
    parameter int TIMERS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [FUNC_W-1:0]        func,
    input  logic [ID_W-1:0]          timer_id,
    input  logic [TIME_W-1:0]        time_us,
    input  logic [DELAY_W-1:0]       delay_ms,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [ID_W-1:0]          fired_id,
    input  logic                     fired,
    input  logic                     status,
    input  logic                     queue_empty,
    input  logic [TIME_W-1:0]        remaining_us,
    input  logic                     last,
    output int                       failures,
    output int                       pending
);
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              fired;
        logic              status;
        logic              empty;
        logic [TIME_W-1:0] rem;
        logic              last;
    } timer_result_t;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    logic [ID_W-1:0]   list_id [TIMERS];
    logic [TIME_W-1:0] list_dl [TIMERS];
    int                fill;
    timer_result_t     expected_results[$];

    assign pending = expected_results.size();

    // Signed 48-bit difference with saturation at both bounds.
    function automatic logic [TIME_W-1:0] time_left(logic [TIME_W-1:0] dl,
                                                    logic [TIME_W-1:0] now);
        logic [TIME_W+1:0] d;
        d = {2'b00, dl} - {2'b00, now};
        if (dl >= now && d[TIME_W-1])
            return {1'b0, {(TIME_W-1){1'b1}}};
        if (dl < now && !d[TIME_W-1])
            return {1'b1, {(TIME_W-1){1'b0}}};
        return d[TIME_W-1:0];
    endfunction

    function automatic int locate(logic [ID_W-1:0] id);
        for (int p = 0; p < fill; p++)
            if (list_id[p] == id)
                return p;
        return -1;
    endfunction

    function automatic void drop(int p);
        for (int q = p; q < fill - 1; q++)
        begin
            list_id[q] = list_id[q + 1];
            list_dl[q] = list_dl[q + 1];
        end
        fill--;
    endfunction

    function automatic void push_result(logic [ID_W-1:0] id, logic f, logic s,
                                        logic [TIME_W-1:0] rem, logic l);
        timer_result_t r;
        r.id = id;
        r.fired = f;
        r.status = s;
        r.empty = (fill == 0);
        r.rem = rem;
        r.last = l;
        expected_results.push_back(r);
    endfunction

    // Works out every result that one accepted command causes.
    function automatic void predict_command(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                            logic [TIME_W-1:0] now,
                                            logic [DELAY_W-1:0] dly);
        int                pos;
        int                p;
        int                n;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] dl;
        logic [TIME_W-1:0] rem;
        logic [ID_W-1:0]   gone[$];
        pos = (id < TIMERS) ? locate(id) : -1;
        case (f)
            FUNC_ARM:
            begin
                if (id >= TIMERS)
                    push_result('0, 1'b0, 1'b1, '0, 1'b1);
                else
                begin
                    if (pos >= 0)
                        drop(pos);
                    sum = {1'b0, now} + ({25'd0, dly} * 49'd1000);
                    dl = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                    p = 0;
                    while (p < fill && list_dl[p] <= dl)
                        p++;
                    for (int q = fill; q > p; q--)
                    begin
                        list_id[q] = list_id[q - 1];
                        list_dl[q] = list_dl[q - 1];
                    end
                    list_id[p] = id;
                    list_dl[p] = dl;
                    fill++;
                    push_result('0, 1'b0, 1'b0, '0, 1'b1);
                end
            end
            FUNC_DISARM, FUNC_FIRE:
            begin
                if (pos < 0)
                    push_result('0, 1'b0, 1'b1, '0, 1'b1);
                else
                begin
                    drop(pos);
                    push_result((f == FUNC_FIRE) ? id : '0, f == FUNC_FIRE, 1'b0, '0, 1'b1);
                end
            end
            FUNC_AGE:
            begin
                while (fill > 0 && list_dl[0] <= now)
                begin
                    gone.push_back(list_id[0]);
                    drop(0);
                end
                rem = (fill > 0) ? time_left(list_dl[0], now) : '0;
                n = gone.size();
                if (n == 0)
                    push_result('0, 1'b0, 1'b0, rem, 1'b1);
                for (int k = 0; k < n; k++)
                    push_result(gone[k], 1'b1, 1'b0, (k == n - 1) ? rem : '0, k == n - 1);
            end
            FUNC_QUERY:
            begin
                if (pos < 0)
                    push_result('0, 1'b0, 1'b1, '0, 1'b1);
                else
                    push_result('0, 1'b0, 1'b0, time_left(list_dl[pos], now), 1'b1);
            end
            default:
                push_result('0, 1'b0, 1'b0, '0, 1'b1);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        if (!rst_n)
        begin
            fill = 0;
            failures <= 0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual id %0d rem %0d",
                             $time, fired_id, remaining_us);
                    failures <= failures + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want != {fired_id, fired, status, queue_empty, remaining_us, last})
                    begin
                        $display("%0t: mismatch, expected id %0d fired %0b status %0b empty %0b rem %0d last %0b",
                                 $time, want.id, want.fired, want.status, want.empty,
                                 $signed(want.rem), want.last);
                        $display("%0t:           actual id %0d fired %0b status %0b empty %0b rem %0d last %0b",
                                 $time, fired_id, fired, status, queue_empty,
                                 $signed(remaining_us), last);
                        failures <= failures + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_command(func, timer_id, time_us, delay_ms);
        end
    end
endmodule

@@ tb/sv/sorted_deadline_timer_queue_unit_test.sv @@
// Testbench top for the sorted deadline timer queue: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module sorted_deadline_timer_queue_unit_test;
    import sdtq_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [FUNC_W-1:0]        func;
    logic [ID_W-1:0]          timer_id;
    logic [TIME_W-1:0]        time_us;
    logic [DELAY_W-1:0]       delay_ms;
    logic                     out_valid;
    logic                     out_stall;
    logic [ID_W-1:0]          fired_id;
    logic                     fired;
    logic                     status;
    logic                     queue_empty;
    logic signed [TIME_W-1:0] remaining_us;
    logic                     last;
    int                       failures;
    int                       pending;
    logic                     hold_receiver;
    logic                     stall_pattern;
    logic [TIME_W-1:0]        clock_now;

    sorted_deadline_timer_queue_unit dut (.*);

    sorted_deadline_timer_queue_unit_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .timer_id(timer_id), .time_us(time_us), .delay_ms(delay_ms),
        .out_valid(out_valid), .out_stall(out_stall), .fired_id(fired_id),
        .fired(fired), .status(status), .queue_empty(queue_empty),
        .remaining_us(remaining_us), .last(last), .failures(failures),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The receiver stalls on its own pseudo-random pattern, which alternates
    // between quiet stretches and busy ones; a long hold-off can be forced
    // by the stimulus process so that the queue backs up into the input.
    initial
    begin
        int mode;
        stall_pattern = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(10, 60))
            begin
                @(posedge clk);
                stall_pattern <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
            end
        end
    end

    assign out_stall = hold_receiver | stall_pattern;

    // Offers one command and holds it until the transfer has taken place.
    task automatic send_command(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                logic [TIME_W-1:0] now, logic [DELAY_W-1:0] dly);
        in_valid <= 1'b1;
        func <= f;
        timer_id <= id;
        time_us <= now;
        delay_ms <= dly;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles)
                @(posedge clk);
        end
    endtask

    // Picks a well-formed command most of the time: arms with short delays
    // against a slowly advancing clock, so that ageing really expires timers.
    task automatic random_command();
        int pick;
        logic [FUNC_W-1:0] f;
        pick = $urandom_range(0, 99);
        clock_now = clock_now + $urandom_range(0, 3000);
        if (pick < 35)
            f = FUNC_ARM;
        else if (pick < 45)
            f = FUNC_DISARM;
        else if (pick < 55)
            f = FUNC_FIRE;
        else if (pick < 80)
            f = FUNC_AGE;
        else if (pick < 94)
            f = FUNC_QUERY;
        else
            f = 3'($urandom_range(5, 7));
        if (pick % 17 == 0)
            send_command(f, 4'($urandom), 48'({$urandom, $urandom}), 24'($urandom));
        else
            send_command(f, 4'($urandom), clock_now, 24'($urandom_range(0, 8)));
    endtask

    initial
    begin
        logic [TIME_W-1:0] top_time;
        top_time = {TIME_W{1'b1}};
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_ARM;
        timer_id = '0;
        time_us = '0;
        delay_ms = '0;
        hold_receiver = 1'b0;
        clock_now = 48'd100000;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty-queue cases, ties, saturation and unknown codes.
        send_command(FUNC_AGE, 4'd0, 48'd0, '0);
        send_command(FUNC_DISARM, 4'd3, 48'd0, '0);
        send_command(FUNC_FIRE, 4'd15, 48'd0, '0);
        send_command(FUNC_QUERY, 4'd7, 48'd0, '0);
        send_command(3'd5, 4'd0, 48'd0, '0);
        send_command(3'd7, 4'd15, top_time, {DELAY_W{1'b1}});
        send_command(FUNC_ARM, 4'd0, 48'd1000, 24'd5);
        send_command(FUNC_ARM, 4'd1, 48'd1000, 24'd5);
        send_command(FUNC_ARM, 4'd2, 48'd0, 24'd1);
        send_command(FUNC_ARM, 4'd15, top_time, {DELAY_W{1'b1}});
        send_command(FUNC_ARM, 4'd14, 48'd0, '0);
        send_command(FUNC_QUERY, 4'd15, 48'd0, '0);
        send_command(FUNC_QUERY, 4'd14, top_time, '0);
        send_command(FUNC_ARM, 4'd1, 48'd0, 24'd2);
        send_command(FUNC_DISARM, 4'd2, 48'd0, '0);
        send_command(FUNC_FIRE, 4'd14, 48'd0, '0);
        send_command(FUNC_AGE, 4'd0, 48'd0, '0);
        send_command(FUNC_AGE, 4'd0, 48'd6000, '0);
        send_command(3'd6, 4'd9, 48'd0, '0);
        send_command(FUNC_AGE, 4'd0, top_time, '0);
        idle_gap(1);

        // Fill the queue while the receiver holds off, so the input backs up.
        fork
            begin
                hold_receiver <= 1'b1;
                repeat (300)
                    @(posedge clk);
                hold_receiver <= 1'b0;
            end
            begin
                for (int i = 0; i < 16; i++)
                    send_command(FUNC_ARM, 4'(i), 48'd50000, 24'($urandom_range(0, 3)));
                idle_gap(1);
            end
        join
        send_command(FUNC_AGE, 4'd0, 48'd60000, '0);
        idle_gap(1);
        while (pending != 0)
            @(posedge clk);

        // Random part in bursts with gaps.
        for (int sent = 0; sent < 150; )
        begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++)
                random_command();
            sent += burst;
            idle_gap($urandom_range(0, 5));
        end
        idle_gap(1);

        while (pending != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
